[rtl/btmx_pkg.sv]
// ----------------------------------------------------------------------------
// btmx_pkg
// shared constants, types and codes of the binary trie max-xor multiset
// ----------------------------------------------------------------------------
package btmx_pkg;

  // key and pool geometry
  localparam int KEY_BITS    = 32;
  localparam int NODE_COUNT  = 131072;
  localparam int COUNT_WIDTH = 20;

  // field widths of the channels
  localparam int KEY_W    = 32;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;

  // derived widths
  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int FREE_W  = $clog2(NODE_COUNT + 1);
  localparam int DEPTH_W = $clog2(KEY_BITS + 1);
  localparam int IDX_W   = $clog2(KEY_BITS);

  typedef logic [NODE_W-1:0]      node_t;
  typedef logic [FREE_W-1:0]      free_t;
  typedef logic [FREE_W:0]        free_ext_t;
  typedef logic [DEPTH_W-1:0]     depth_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [KEY_W-1:0]       key_t;

  localparam count_t CNT_MAX = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_POOL_FULL = 3'd1,
    ST_ABSENT    = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  // one node of the pool: both child links and the pass count
  typedef struct packed {
    node_t  link1;
    node_t  link0;
    count_t count;
  } row_t;

  // what the datapath does with the row read in the previous cycle
  typedef enum logic [2:0] {
    EV_NONE,
    EV_PROBE,
    EV_UPDATE,
    EV_QROOT,
    EV_QCHILD
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_PROBE_RD,
    S_PROBE_EV,
    S_UPD_RD,
    S_UPD_EV,
    S_QROOT_RD,
    S_QROOT_EV,
    S_QCHILD_RD,
    S_QCHILD_EV,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic  load;
    logic  rewind;
    mode_t mode;
    logic  rd_child;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    early;
    logic    walk_end;
    logic    proceed;
    logic    out_free;
  } sts_t;

endpackage

[rtl/btmx_item_if.sv]
// ----------------------------------------------------------------------------
// btmx_item_if
// input channel: action and key with valid/ready
// ----------------------------------------------------------------------------
interface btmx_item_if;
  logic                          valid;
  logic                          ready;
  logic [btmx_pkg::ACTION_W-1:0] action;
  logic [btmx_pkg::KEY_W-1:0]    key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

[rtl/btmx_result_if.sv]
// ----------------------------------------------------------------------------
// btmx_result_if
// result channel: best xor, found flag and status with valid/ready
// ----------------------------------------------------------------------------
interface btmx_result_if;
  logic                          valid;
  logic                          ready;
  logic [btmx_pkg::KEY_W-1:0]    xor_best;
  logic                          found;
  logic [btmx_pkg::STATUS_W-1:0] status;

  modport source (output valid, output xor_best, output found, output status, input ready);
  modport sink   (input valid, input xor_best, input found, input status, output ready);
endinterface

[rtl/binary_trie_max_xor_multiset.sv]
// ----------------------------------------------------------------------------
// binary_trie_max_xor_multiset
// multiset of 32-bit keys in a binary trie with insert, remove, search and
// maximum-xor query. One item is worked at a time; every trie level costs an
// address out and a registered row back, because each level's node address
// comes from the row read at the level above, so the single node pool memory
// sets the pace. A search, an absent remove or a refused insert walks once;
// a query reads the root and then up to 32 levels, each reading both children
// side by side, one on each read port; an insert or a successful remove walks
// twice, once to check and once to write the counts back. Overflowing inserts
// and queries on an empty set answer without a walk. The next item is taken in
// the cycle after the result has moved into the output register, even while
// that result still waits to be taken; while an earlier result still sits
// there, the finished walk waits and the input is stalled. No beat is taken
// while reset is held. No clearing pass after reset: nodes are handed out in
// order and a node's row is written in full on the walk that allocates it, so
// nothing beyond the free-node pointer is ever read before it is written.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_multiset (
  input logic           clk,
  input logic           rst,
  btmx_item_if.sink     item,
  btmx_result_if.source result
);

  btmx_pkg::cmd_t cmd;
  btmx_pkg::sts_t sts;
  logic           item_ready;

  // sequencer: accepts a beat in idle, then steps the walks
  btmx_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  assign item.ready = item_ready;

  // node pool, walk registers and the output register of the result beat
  btmx_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .item_action     (item.action),
    .item_key        (item.key),
    .result_ready    (result.ready),
    .result_valid    (result.valid),
    .result_xor_best (result.xor_best),
    .result_found    (result.found),
    .result_status   (result.status)
  );

endmodule

[rtl/btmx_datapath.sv]
// ----------------------------------------------------------------------------
// btmx_datapath
// node pool memory, walk registers, counters and the result register
// ----------------------------------------------------------------------------
module btmx_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  btmx_pkg::cmd_t                cmd,
  output btmx_pkg::sts_t                sts,
  input  logic [btmx_pkg::ACTION_W-1:0] item_action,
  input  logic [btmx_pkg::KEY_W-1:0]    item_key,
  input  logic                          result_ready,
  output logic                          result_valid,
  output logic [btmx_pkg::KEY_W-1:0]    result_xor_best,
  output logic                          result_found,
  output logic [btmx_pkg::STATUS_W-1:0] result_status
);

  // node pool, one row per node
  btmx_pkg::row_t mem [btmx_pkg::NODE_COUNT];

  btmx_pkg::row_t    rd_a;
  btmx_pkg::row_t    rd_b;
  btmx_pkg::row_t    row_a;
  btmx_pkg::row_t    wr_row;
  btmx_pkg::row_t    pick_row;
  btmx_pkg::node_t   cur;
  btmx_pkg::node_t   link0_q;
  btmx_pkg::node_t   link1_q;
  btmx_pkg::node_t   link;
  btmx_pkg::node_t   new_node;
  btmx_pkg::node_t   next_cur;
  btmx_pkg::node_t   addr_a;
  btmx_pkg::free_t   next_free;
  btmx_pkg::free_ext_t need;
  btmx_pkg::depth_t  depth;
  btmx_pkg::idx_t    bit_idx;
  btmx_pkg::count_t  total;
  btmx_pkg::key_t    key_q;
  btmx_pkg::key_t    xor_acc;
  btmx_pkg::action_t act_q;
  btmx_pkg::action_t ld_act;
  btmx_pkg::status_t status_q;
  btmx_pkg::status_t ld_status;

  logic fresh;
  logic root_init;
  logic found_q;
  logic kbit;
  logic at_leaf;
  logic at_last;
  logic is_ins;
  logic pool_ok;
  logic leaf_ok;
  logic alloc;
  logic ok0;
  logic ok1;
  logic want_ok;
  logic same_ok;
  logic pick_bit;
  logic walk_end;
  logic wr_en;

  // ---- memory: one write port, two registered read ports
  assign addr_a = cmd.rd_child ? link0_q : cur;
  assign wr_en  = (cmd.mode == btmx_pkg::EV_UPDATE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur] <= wr_row;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[link1_q];
  end

  // ---- step logic
  always_comb begin
    bit_idx = btmx_pkg::idx_t'(btmx_pkg::KEY_BITS - 1) - depth[btmx_pkg::IDX_W-1:0];
    kbit    = key_q[bit_idx];
    at_leaf = (depth == btmx_pkg::depth_t'(btmx_pkg::KEY_BITS));
    at_last = (depth == btmx_pkg::depth_t'(btmx_pkg::KEY_BITS - 1));
    is_ins  = (act_q == btmx_pkg::ACT_INSERT);

    // a freshly allocated node (or the unwritten root) reads as empty
    row_a = fresh ? '0 : rd_a;
    link  = kbit ? row_a.link1 : row_a.link0;

    // nodes an insert still needs below the first missing link
    need    = btmx_pkg::free_ext_t'(btmx_pkg::KEY_BITS) - btmx_pkg::free_ext_t'(depth);
    pool_ok = (btmx_pkg::free_ext_t'(next_free) + need)
              <= btmx_pkg::free_ext_t'(btmx_pkg::NODE_COUNT);
    leaf_ok = at_leaf && (row_a.count != '0);

    alloc    = is_ins && !at_leaf && (link == '0);
    new_node = next_free[btmx_pkg::NODE_W-1:0];
    next_cur = alloc ? new_node : link;

    wr_row = row_a;
    if (is_ins) begin
      wr_row.count = row_a.count + 1'b1;
    end else if (row_a.count != '0) begin
      wr_row.count = row_a.count - 1'b1;
    end
    if (alloc) begin
      if (kbit) begin
        wr_row.link1 = new_node;
      end else begin
        wr_row.link0 = new_node;
      end
    end

    // query: both children read side by side
    ok0      = (link0_q != '0) && (rd_a.count != '0);
    ok1      = (link1_q != '0) && (rd_b.count != '0);
    want_ok  = kbit ? ok0 : ok1;
    same_ok  = kbit ? ok1 : ok0;
    pick_bit = want_ok ? ~kbit : kbit;
    pick_row = pick_bit ? rd_b : rd_a;

    unique case (cmd.mode)
      btmx_pkg::EV_PROBE:  walk_end = at_leaf || (link == '0);
      btmx_pkg::EV_UPDATE: walk_end = at_leaf;
      btmx_pkg::EV_QCHILD: walk_end = !(want_ok || same_ok) || at_last;
      default:             walk_end = 1'b0;
    endcase

    ld_act = btmx_pkg::action_t'(item_action);
    if (ld_act == btmx_pkg::ACT_INSERT && total == btmx_pkg::CNT_MAX) begin
      ld_status = btmx_pkg::ST_OVERFLOW;
    end else if (ld_act == btmx_pkg::ACT_QUERY && total == '0) begin
      ld_status = btmx_pkg::ST_EMPTY;
    end else begin
      ld_status = btmx_pkg::ST_OK;
    end
  end

  assign sts.act      = act_q;
  assign sts.early    = (status_q != btmx_pkg::ST_OK);
  assign sts.walk_end = walk_end;
  assign sts.proceed  = is_ins ? pool_ok : leaf_ok;
  assign sts.out_free = !result_valid || result_ready;

  // ---- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      next_free    <= btmx_pkg::free_t'(1);
      root_init    <= 1'b0;
      total        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (wr_en) begin
        root_init <= 1'b1;
        if (alloc) begin
          next_free <= next_free + 1'b1;
        end
        if (at_leaf) begin
          total <= is_ins ? total + 1'b1 : total - 1'b1;
        end
      end
    end
  end

  // ---- walk and payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q    <= ld_act;
      key_q    <= item_key;
      status_q <= ld_status;
      found_q  <= 1'b0;
      xor_acc  <= '0;
      cur      <= '0;
      fresh    <= !root_init;
      depth    <= '0;
    end else begin
      unique case (cmd.mode)
        btmx_pkg::EV_PROBE: begin
          if (walk_end) begin
            if (act_q == btmx_pkg::ACT_INSERT && !pool_ok) begin
              status_q <= btmx_pkg::ST_POOL_FULL;
            end
            if (act_q == btmx_pkg::ACT_REMOVE && !leaf_ok) begin
              status_q <= btmx_pkg::ST_ABSENT;
            end
            if (act_q == btmx_pkg::ACT_SEARCH) begin
              found_q <= leaf_ok;
            end
          end else begin
            cur   <= link;
            fresh <= 1'b0;
            depth <= depth + 1'b1;
          end
        end
        btmx_pkg::EV_UPDATE: begin
          if (!at_leaf) begin
            cur   <= next_cur;
            fresh <= alloc;
            depth <= depth + 1'b1;
          end
        end
        btmx_pkg::EV_QROOT: begin
          link0_q <= rd_a.link0;
          link1_q <= rd_a.link1;
        end
        btmx_pkg::EV_QCHILD: begin
          if (want_ok || same_ok) begin
            if (want_ok) begin
              xor_acc[bit_idx] <= 1'b1;
            end
            link0_q <= pick_row.link0;
            link1_q <= pick_row.link1;
            depth   <= depth + 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (cmd.rewind) begin
        cur   <= '0;
        fresh <= !root_init;
        depth <= '0;
      end
    end
    if (cmd.emit) begin
      result_xor_best <= xor_acc;
      result_found    <= found_q;
      result_status   <= status_q;
    end
  end

`ifndef SYNTHESIS
  a_free_range: assert property (@(posedge clk) disable iff (rst)
    (next_free != '0) &&
    (btmx_pkg::free_ext_t'(next_free) <= btmx_pkg::free_ext_t'(btmx_pkg::NODE_COUNT)))
    else $error("free node pointer out of range");

  a_write_owned: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (btmx_pkg::free_ext_t'(cur) < btmx_pkg::free_ext_t'(next_free)))
    else $error("row written for a node never allocated");

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.mode != btmx_pkg::EV_NONE) |->
    (depth <= btmx_pkg::depth_t'(btmx_pkg::KEY_BITS)))
    else $error("walk went below the leaf level");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!result_valid || result_ready))
    else $error("result register overwritten before it was taken");

  a_total_insert: assert property (@(posedge clk) disable iff (rst)
    (wr_en && at_leaf && is_ins) |=> (total == $past(total) + 1'b1))
    else $error("key total not raised by a finished insert");
`endif

endmodule

[rtl/btmx_ctrl.sv]
// ----------------------------------------------------------------------------
// btmx_ctrl
// sequencer of the trie walks: probe, update and query
// ----------------------------------------------------------------------------
module btmx_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  btmx_pkg::sts_t sts,
  output btmx_pkg::cmd_t cmd
);

  btmx_pkg::state_t state;
  btmx_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btmx_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.rewind   = 1'b0;
    cmd.mode     = btmx_pkg::EV_NONE;
    cmd.rd_child = 1'b0;
    cmd.emit     = 1'b0;
    item_ready   = 1'b0;

    unique case (state)
      btmx_pkg::S_IDLE: begin
        // no beat is taken while reset is held
        item_ready = !rst;
        if (item_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = btmx_pkg::S_START;
        end
      end
      btmx_pkg::S_START: begin
        if (sts.early) begin
          state_next = btmx_pkg::S_RESULT;
        end else if (sts.act == btmx_pkg::ACT_QUERY) begin
          state_next = btmx_pkg::S_QROOT_RD;
        end else begin
          state_next = btmx_pkg::S_PROBE_RD;
        end
      end
      btmx_pkg::S_PROBE_RD: begin
        state_next = btmx_pkg::S_PROBE_EV;
      end
      btmx_pkg::S_PROBE_EV: begin
        cmd.mode = btmx_pkg::EV_PROBE;
        if (!sts.walk_end) begin
          state_next = btmx_pkg::S_PROBE_RD;
        end else if ((sts.act == btmx_pkg::ACT_INSERT || sts.act == btmx_pkg::ACT_REMOVE)
                     && sts.proceed) begin
          cmd.rewind = 1'b1;
          state_next = btmx_pkg::S_UPD_RD;
        end else begin
          state_next = btmx_pkg::S_RESULT;
        end
      end
      btmx_pkg::S_UPD_RD: begin
        state_next = btmx_pkg::S_UPD_EV;
      end
      btmx_pkg::S_UPD_EV: begin
        cmd.mode   = btmx_pkg::EV_UPDATE;
        state_next = sts.walk_end ? btmx_pkg::S_RESULT : btmx_pkg::S_UPD_RD;
      end
      btmx_pkg::S_QROOT_RD: begin
        state_next = btmx_pkg::S_QROOT_EV;
      end
      btmx_pkg::S_QROOT_EV: begin
        cmd.mode   = btmx_pkg::EV_QROOT;
        state_next = btmx_pkg::S_QCHILD_RD;
      end
      btmx_pkg::S_QCHILD_RD: begin
        cmd.rd_child = 1'b1;
        state_next   = btmx_pkg::S_QCHILD_EV;
      end
      btmx_pkg::S_QCHILD_EV: begin
        cmd.mode   = btmx_pkg::EV_QCHILD;
        state_next = sts.walk_end ? btmx_pkg::S_RESULT : btmx_pkg::S_QCHILD_RD;
      end
      btmx_pkg::S_RESULT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = btmx_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = btmx_pkg::S_IDLE;
      end
    endcase
  end

endmodule
